[rtl/ppcr_pkg.sv]
// ----------------------------------------------------------------------------
// ppcr_pkg
// Types, widths and helpers shared by the disc pair collision response block.
// ----------------------------------------------------------------------------
`default_nettype none

package ppcr_pkg;

   localparam int WORD_W     = 32;
   localparam int MASS_W     = 16;
   localparam int RAD_W      = 25;
   localparam int GAIN_W     = 17;
   localparam int GAIN_FRAC  = 16;
   localparam int UNIT_FRAC  = 28;
   localparam int MAG_W      = 26;   // |d| and radius sum when in contact
   localparam int SQ_W       = 52;   // |d|^2 when in contact
   localparam int ROOT_STEPS = 26;   // one root bit per stage
   localparam int WQ_STEPS   = 18;   // mass weight quotient bits
   localparam int UNIT_STEPS = 29;   // unit vector quotient bits
   localparam int DIV_STAGES = ROOT_STEPS + UNIT_STEPS;

   typedef enum logic [1:0] {
      ST_APART      = 2'd0,
      ST_RESOLVED   = 2'd1,
      ST_COINCIDENT = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] first_pos_x;
      logic signed [WORD_W-1:0] first_pos_y;
      logic signed [WORD_W-1:0] first_vel_x;
      logic signed [WORD_W-1:0] first_vel_y;
      logic [MASS_W-1:0]        first_mass;
      logic [RAD_W-1:0]         first_radius;
      logic signed [WORD_W-1:0] second_pos_x;
      logic signed [WORD_W-1:0] second_pos_y;
      logic signed [WORD_W-1:0] second_vel_x;
      logic signed [WORD_W-1:0] second_vel_y;
      logic [MASS_W-1:0]        second_mass;
      logic [RAD_W-1:0]         second_radius;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] new_first_pos_x;
      logic signed [WORD_W-1:0] new_first_pos_y;
      logic signed [WORD_W-1:0] new_first_vel_x;
      logic signed [WORD_W-1:0] new_first_vel_y;
      logic signed [WORD_W-1:0] new_second_pos_x;
      logic signed [WORD_W-1:0] new_second_pos_y;
      logic signed [WORD_W-1:0] new_second_vel_x;
      logic signed [WORD_W-1:0] new_second_vel_y;
      logic [1:0]               contact_status;
   } rsp_type;

   // classified pair handed from front to back
   typedef struct packed {
      req_type          item;
      status_type       status;
      logic             dx_neg;
      logic             dy_neg;
      logic [MAG_W-1:0] adx;
      logic [MAG_W-1:0] ady;
      logic [MAG_W-1:0] rsum;
      logic [SQ_W-1:0]  d2;
   } fr_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [WORD_W-1:0] sat32(input logic signed [47:0] v);
      logic [WORD_W-1:0] r;
      if (v > 48'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -48'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/ppcr_chan_if.sv]
// ----------------------------------------------------------------------------
// ppcr channel interfaces
// Valid/ready channels for pair items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppcr_req_if;
   logic              valid;
   logic              ready;
   ppcr_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ppcr_rsp_if;
   logic              valid;
   logic              ready;
   ppcr_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/particle_pair_collision_resolve.sv]
// ----------------------------------------------------------------------------
// particle_pair_collision_resolve
// Elastic 2D disc pair collision response with damping and separation.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one particle pair per item; rsp_bus returns one result
//   item per pair, in order. The csr port holds damping_gain at byte 0;
//   write it only while no pair is in flight.
// Throughput: one pair per cycle while the receiver does not stall. Every stage is fully pipelined:
//   the square root yields one bit per stage (26 stages), then both unit
//   vector dividers one bit per stage (29 stages); the mass weight divider
//   runs alongside the root stages.
// Stages: an accepted pair passes 3 classify stages, the queue, 55 root/divide
//   stages and 6 arithmetic stages before rsp_bus.valid.
// Stall: with rsp_bus.valid high, a low rsp_bus.ready freezes the response
//   pipeline; the two-entry queue absorbs classifier items, then req_bus.ready drops.
// Reset: synchronous; clears all valid state, empties the queue and sets
//   damping_gain to 1.0 (65536). No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_pair_collision_resolve (
   input  wire logic        clock,
   input  wire logic        reset,
   ppcr_req_if.sink         req_bus,
   ppcr_rsp_if.source       rsp_bus,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic CSR_IDX_GAIN = 1'b0;

   logic [16:0]         gain_ff;
   logic                csr_wr;
   logic                push, pop;
   ppcr_pkg::fr_type    push_data, head;
   ppcr_pkg::qstat_type q_stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_GAIN) ? {15'd0, gain_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 17'd65536;
      end else if (csr_wr && (csr_paddr[2] == CSR_IDX_GAIN)) begin
         gain_ff <= csr_pwdata[16:0];
      end
   end

   ppcr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   ppcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   ppcr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_stat  (q_stat),
      .head    (head),
      .pop     (pop),
      .gain    (gain_ff),
      .rsp_bus (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.data.contact_status == ppcr_pkg::ST_APART ||
                         rsp_bus.data.contact_status == ppcr_pkg::ST_RESOLVED ||
                         rsp_bus.data.contact_status == ppcr_pkg::ST_COINCIDENT))
      else $error("invalid contact status");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid right after reset");

   a_gain_write : assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_paddr[2] == CSR_IDX_GAIN) |=> gain_ff == $past(csr_pwdata[16:0]))
      else $error("gain register not written");

   a_queue_state : assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !q_stat.empty && !pop |=> q_stat.full || !push)
      else $error("queue state inconsistent");
`endif

endmodule

`default_nettype wire

[rtl/ppcr_front.sv]
// ----------------------------------------------------------------------------
// ppcr_front
// Accepts pairs, forms center offsets and squared distances, classifies contact.
// ----------------------------------------------------------------------------
`default_nettype none

module ppcr_front (
   input  wire logic           clock,
   input  wire logic           reset,
   ppcr_req_if.sink            req_bus,
   input  ppcr_pkg::qstat_type q_stat,
   output logic                push,
   output ppcr_pkg::fr_type    push_data
);

   logic fen;

   logic signed [32:0] dx_in, dy_in;
   logic [32:0]        adx_in, ady_in;
   logic [25:0]        rsum_in;
   logic               close_in;

   logic              f1_vld_ff, f2_vld_ff, f3_vld_ff;
   ppcr_pkg::req_type f1_item_ff, f2_item_ff;
   logic              f1_dxn_ff, f1_dyn_ff, f2_dxn_ff, f2_dyn_ff;
   logic [25:0]       f1_adx_ff, f1_ady_ff, f2_adx_ff, f2_ady_ff;
   logic [25:0]       f1_rsum_ff, f2_rsum_ff;
   logic              f1_close_ff, f2_close_ff;
   logic [51:0]       f2_sqx_ff, f2_sqy_ff, f2_r2_ff;
   logic [52:0]       d2_sum;
   ppcr_pkg::fr_type  f3_in, f3_ff;

   assign fen           = !f3_vld_ff || !q_stat.full;
   assign req_bus.ready = fen;
   assign push          = f3_vld_ff && !q_stat.full;
   assign push_data     = f3_ff;

   always_comb begin
      dx_in = $signed({req_bus.data.first_pos_x[31], req_bus.data.first_pos_x})
            - $signed({req_bus.data.second_pos_x[31], req_bus.data.second_pos_x});
      dy_in = $signed({req_bus.data.first_pos_y[31], req_bus.data.first_pos_y})
            - $signed({req_bus.data.second_pos_y[31], req_bus.data.second_pos_y});
      adx_in = dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
      ady_in = dy_in[32] ? 33'(-dy_in) : 33'(dy_in);
      rsum_in = {1'b0, req_bus.data.first_radius} + {1'b0, req_bus.data.second_radius};
      close_in = (adx_in <= {7'd0, rsum_in}) && (ady_in <= {7'd0, rsum_in});
   end

   always_comb begin
      d2_sum = {1'b0, f2_sqx_ff} + {1'b0, f2_sqy_ff};
      f3_in.item   = f2_item_ff;
      f3_in.dx_neg = f2_dxn_ff;
      f3_in.dy_neg = f2_dyn_ff;
      f3_in.adx    = f2_adx_ff;
      f3_in.ady    = f2_ady_ff;
      f3_in.rsum   = f2_rsum_ff;
      f3_in.d2     = d2_sum[51:0];
      if (!f2_close_ff || (d2_sum > {1'b0, f2_r2_ff})) begin
         f3_in.status = ppcr_pkg::ST_APART;
      end else if (d2_sum == 53'd0) begin
         f3_in.status = ppcr_pkg::ST_COINCIDENT;
      end else begin
         f3_in.status = ppcr_pkg::ST_RESOLVED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         f3_vld_ff <= 1'b0;
      end else if (fen) begin
         f1_vld_ff <= req_bus.valid;
         f2_vld_ff <= f1_vld_ff;
         f3_vld_ff <= f2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fen) begin
         f1_item_ff  <= req_bus.data;
         f1_dxn_ff   <= dx_in[32];
         f1_dyn_ff   <= dy_in[32];
         f1_adx_ff   <= adx_in[25:0];
         f1_ady_ff   <= ady_in[25:0];
         f1_rsum_ff  <= rsum_in;
         f1_close_ff <= close_in;
         f2_item_ff  <= f1_item_ff;
         f2_dxn_ff   <= f1_dxn_ff;
         f2_dyn_ff   <= f1_dyn_ff;
         f2_adx_ff   <= f1_adx_ff;
         f2_ady_ff   <= f1_ady_ff;
         f2_rsum_ff  <= f1_rsum_ff;
         f2_close_ff <= f1_close_ff;
         f2_sqx_ff   <= {26'd0, f1_adx_ff} * {26'd0, f1_adx_ff};
         f2_sqy_ff   <= {26'd0, f1_ady_ff} * {26'd0, f1_ady_ff};
         f2_r2_ff    <= {26'd0, f1_rsum_ff} * {26'd0, f1_rsum_ff};
         f3_ff       <= f3_in;
      end
   end

endmodule

`default_nettype wire

[rtl/ppcr_queue.sv]
// ----------------------------------------------------------------------------
// ppcr_queue
// Two-entry queue between the classifier and the response pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ppcr_queue (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  ppcr_pkg::fr_type    push_data,
   input  wire logic           pop,
   output ppcr_pkg::fr_type    head,
   output ppcr_pkg::qstat_type q_stat
);

   localparam int DEPTH = 2;

   ppcr_pkg::fr_type entry_ff [DEPTH];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   assign head         = entry_ff[rd_ptr_ff];
   assign q_stat.empty = (count_ff == 2'd0);
   assign q_stat.full  = (count_ff == 2'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/ppcr_back.sv]
// ----------------------------------------------------------------------------
// ppcr_back
// Root and divider pipeline, then velocity exchange, damping and separation.
// ----------------------------------------------------------------------------
`default_nettype none

module ppcr_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  ppcr_pkg::qstat_type q_stat,
   input  ppcr_pkg::fr_type    head,
   output logic                pop,
   input  wire logic [16:0]    gain,
   ppcr_rsp_if.source          rsp_bus
);

   localparam int NB = ppcr_pkg::DIV_STAGES;

   typedef struct packed {
      ppcr_pkg::req_type    item;
      ppcr_pkg::status_type status;
      logic                 dx_neg;
      logic                 dy_neg;
      logic [25:0]          rsum;
      logic [51:0]          sq_n;
      logic [27:0]          sq_rem;
      logic [25:0]          root;
      logic [16:0]          msum;
      logic [17:0]          m_rem1;
      logic [17:0]          m_rem2;
      logic [17:0]          w1;
      logic [17:0]          w2;
      logic [26:0]          u_remx;
      logic [26:0]          u_remy;
      logic [28:0]          uqx;
      logic [28:0]          uqy;
   } bk_type;

   function automatic logic [18:0] mstep(input logic [17:0] rem, input logic [16:0] den);
      logic        ge;
      logic [17:0] diff;
      ge   = rem >= {1'b0, den};
      diff = ge ? rem - {1'b0, den} : rem;
      return {ge, diff[16:0], 1'b0};
   endfunction

   function automatic logic [27:0] ustep(input logic [26:0] rem, input logic [25:0] den);
      logic        ge;
      logic [26:0] diff;
      ge   = rem >= {1'b0, den};
      diff = ge ? rem - {1'b0, den} : rem;
      return {ge, diff[25:0], 1'b0};
   endfunction

   function automatic bk_type div_step(input bk_type s, input int k);
      bk_type      r;
      logic [27:0] rem;
      logic [27:0] trial;
      logic        ge;
      logic [18:0] mr1, mr2;
      logic [27:0] ur;
      r = s;
      if (k < ppcr_pkg::ROOT_STEPS) begin
         rem   = {s.sq_rem[25:0], s.sq_n[51:50]};
         trial = {1'b0, s.root[24:0], 2'b01};
         ge    = rem >= trial;
         r.sq_rem = ge ? rem - trial : rem;
         r.root   = {s.root[24:0], ge};
         r.sq_n   = {s.sq_n[49:0], 2'b00};
      end
      if (k < ppcr_pkg::WQ_STEPS) begin
         mr1 = mstep(s.m_rem1, s.msum);
         mr2 = mstep(s.m_rem2, s.msum);
         r.m_rem1 = mr1[17:0];
         r.m_rem2 = mr2[17:0];
         r.w1     = {s.w1[16:0], mr1[18]};
         r.w2     = {s.w2[16:0], mr2[18]};
      end
      if (k >= ppcr_pkg::ROOT_STEPS) begin
         ur = ustep(s.u_remx, s.root);
         r.u_remx = ur[26:0];
         r.uqx    = {s.uqx[27:0], ur[27]};
         ur = ustep(s.u_remy, s.root);
         r.u_remy = ur[26:0];
         r.uqy    = {s.uqy[27:0], ur[27]};
      end
      return r;
   endfunction

   logic   ben;
   bk_type load;
   bk_type sin [NB];
   logic   vin [NB];
   bk_type st_ff [NB];
   logic   vld_ff [NB];

   assign ben = !rsp_bus.valid || rsp_bus.ready;
   assign pop = ben && !q_stat.empty;

   always_comb begin
      load.item   = head.item;
      load.status = head.status;
      load.dx_neg = head.dx_neg;
      load.dy_neg = head.dy_neg;
      load.rsum   = head.rsum;
      load.sq_n   = head.d2;
      load.sq_rem = 28'd0;
      load.root   = 26'd0;
      load.msum   = {1'b0, head.item.first_mass} + {1'b0, head.item.second_mass};
      load.m_rem1 = {2'd0, head.item.second_mass};
      load.m_rem2 = {2'd0, head.item.first_mass};
      load.w1     = 18'd0;
      load.w2     = 18'd0;
      load.u_remx = {1'b0, head.adx};
      load.u_remy = {1'b0, head.ady};
      load.uqx    = 29'd0;
      load.uqy    = 29'd0;
   end

   for (genvar k = 0; k < NB; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign sin[k] = load;
         assign vin[k] = !q_stat.empty;
      end else begin : g_next
         assign sin[k] = st_ff[k-1];
         assign vin[k] = vld_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (ben) begin
            vld_ff[k] <= vin[k];
         end
      end
      always_ff @(posedge clock) begin
         if (ben) begin
            st_ff[k] <= div_step(sin[k], k);
         end
      end
   end

   // response arithmetic
   bk_type             t;
   logic signed [29:0] ux_c, uy_c;
   logic signed [32:0] dvx_c, dvy_c;
   logic signed [26:0] ov_c;
   logic [17:0]        w1_c, w2_c;

   logic [5:0] mv_ff;

   ppcr_pkg::req_type    m1_item_ff, m2_item_ff, m3_item_ff, m4_item_ff, m5_item_ff;
   ppcr_pkg::status_type m1_st_ff, m2_st_ff, m3_st_ff, m4_st_ff, m5_st_ff;
   logic signed [29:0]   m1_ux_ff, m1_uy_ff, m2_ux_ff, m2_uy_ff, m3_ux_ff, m3_uy_ff;
   logic signed [62:0]   m1_pdx_ff, m1_pdy_ff;
   logic signed [56:0]   m1_ppx_ff, m1_ppy_ff;
   logic [17:0]          m1_w1_ff, m1_w2_ff, m2_w1_ff, m2_w2_ff;
   logic signed [35:0]   m2_vn_ff;
   logic [31:0]          m2_p1x_ff, m2_p1y_ff, m2_p2x_ff, m2_p2y_ff;
   logic [31:0]          m3_p1x_ff, m3_p1y_ff, m3_p2x_ff, m3_p2y_ff;
   logic [31:0]          m4_p1x_ff, m4_p1y_ff, m4_p2x_ff, m4_p2y_ff;
   logic [31:0]          m5_p1x_ff, m5_p1y_ff, m5_p2x_ff, m5_p2y_ff;
   logic signed [38:0]   m3_j1_ff, m3_j2_ff;
   logic signed [68:0]   m4_t1x_ff, m4_t1y_ff, m4_t2x_ff, m4_t2y_ff;
   logic signed [41:0]   m5_n1x_ff, m5_n1y_ff, m5_n2x_ff, m5_n2y_ff;
   ppcr_pkg::rsp_type    m6_ff;

   logic signed [63:0] dot_c;
   logic signed [27:0] px_c, py_c;
   logic signed [54:0] jp1_c, jp2_c;
   logic signed [17:0] g_c;
   logic signed [59:0] g1x_c, g1y_c, g2x_c, g2y_c;
   logic               res2, res5;

   always_comb begin
      t     = st_ff[NB-1];
      ux_c  = t.dx_neg ? -$signed({1'b0, t.uqx}) : $signed({1'b0, t.uqx});
      uy_c  = t.dy_neg ? -$signed({1'b0, t.uqy}) : $signed({1'b0, t.uqy});
      dvx_c = $signed({t.item.first_vel_x[31], t.item.first_vel_x})
            - $signed({t.item.second_vel_x[31], t.item.second_vel_x});
      dvy_c = $signed({t.item.first_vel_y[31], t.item.first_vel_y})
            - $signed({t.item.second_vel_y[31], t.item.second_vel_y});
      ov_c  = $signed({1'b0, t.rsum}) - $signed({1'b0, t.root});
      // both masses zero: equal weights of one
      w1_c  = (t.msum == 17'd0) ? 18'd65536 : t.w1;
      w2_c  = (t.msum == 17'd0) ? 18'd65536 : t.w2;

      dot_c = 64'(m1_pdx_ff) + 64'(m1_pdy_ff);
      px_c  = $signed(m1_ppx_ff[56:29]);
      py_c  = $signed(m1_ppy_ff[56:29]);
      res2  = (m1_st_ff == ppcr_pkg::ST_RESOLVED);

      jp1_c = 55'(m2_vn_ff) * 55'($signed({1'b0, m2_w1_ff}));
      jp2_c = 55'(m2_vn_ff) * 55'($signed({1'b0, m2_w2_ff}));

      g_c   = $signed({1'b0, gain});
      g1x_c = 60'(m5_n1x_ff) * 60'(g_c);
      g1y_c = 60'(m5_n1y_ff) * 60'(g_c);
      g2x_c = 60'(m5_n2x_ff) * 60'(g_c);
      g2y_c = 60'(m5_n2y_ff) * 60'(g_c);
      res5  = (m5_st_ff == ppcr_pkg::ST_RESOLVED);
   end

   assign rsp_bus.valid = mv_ff[5];
   assign rsp_bus.data  = m6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 6'd0;
      end else if (ben) begin
         mv_ff <= {mv_ff[4:0], vld_ff[NB-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (ben) begin
         m1_item_ff <= t.item;
         m1_st_ff   <= t.status;
         m1_ux_ff   <= ux_c;
         m1_uy_ff   <= uy_c;
         m1_pdx_ff  <= 63'(dvx_c) * 63'(ux_c);
         m1_pdy_ff  <= 63'(dvy_c) * 63'(uy_c);
         m1_ppx_ff  <= 57'(ux_c) * 57'(ov_c);
         m1_ppy_ff  <= 57'(uy_c) * 57'(ov_c);
         m1_w1_ff   <= w1_c;
         m1_w2_ff   <= w2_c;

         m2_item_ff <= m1_item_ff;
         m2_st_ff   <= m1_st_ff;
         m2_ux_ff   <= m1_ux_ff;
         m2_uy_ff   <= m1_uy_ff;
         m2_w1_ff   <= m1_w1_ff;
         m2_w2_ff   <= m1_w2_ff;
         m2_vn_ff   <= $signed(dot_c[63:28]);
         if (res2) begin
            m2_p1x_ff <= ppcr_pkg::sat32(48'(m1_item_ff.first_pos_x) + 48'(px_c));
            m2_p1y_ff <= ppcr_pkg::sat32(48'(m1_item_ff.first_pos_y) + 48'(py_c));
            m2_p2x_ff <= ppcr_pkg::sat32(48'(m1_item_ff.second_pos_x) - 48'(px_c));
            m2_p2y_ff <= ppcr_pkg::sat32(48'(m1_item_ff.second_pos_y) - 48'(py_c));
         end else begin
            m2_p1x_ff <= m1_item_ff.first_pos_x;
            m2_p1y_ff <= m1_item_ff.first_pos_y;
            m2_p2x_ff <= m1_item_ff.second_pos_x;
            m2_p2y_ff <= m1_item_ff.second_pos_y;
         end

         m3_item_ff <= m2_item_ff;
         m3_st_ff   <= m2_st_ff;
         m3_ux_ff   <= m2_ux_ff;
         m3_uy_ff   <= m2_uy_ff;
         m3_j1_ff   <= $signed(jp1_c[54:16]);
         m3_j2_ff   <= $signed(jp2_c[54:16]);
         m3_p1x_ff  <= m2_p1x_ff;
         m3_p1y_ff  <= m2_p1y_ff;
         m3_p2x_ff  <= m2_p2x_ff;
         m3_p2y_ff  <= m2_p2y_ff;

         m4_item_ff <= m3_item_ff;
         m4_st_ff   <= m3_st_ff;
         m4_t1x_ff  <= 69'(m3_j1_ff) * 69'(m3_ux_ff);
         m4_t1y_ff  <= 69'(m3_j1_ff) * 69'(m3_uy_ff);
         m4_t2x_ff  <= 69'(m3_j2_ff) * 69'(m3_ux_ff);
         m4_t2y_ff  <= 69'(m3_j2_ff) * 69'(m3_uy_ff);
         m4_p1x_ff  <= m3_p1x_ff;
         m4_p1y_ff  <= m3_p1y_ff;
         m4_p2x_ff  <= m3_p2x_ff;
         m4_p2y_ff  <= m3_p2y_ff;

         m5_item_ff <= m4_item_ff;
         m5_st_ff   <= m4_st_ff;
         m5_n1x_ff  <= 42'(m4_item_ff.first_vel_x) - 42'($signed(m4_t1x_ff[68:28]));
         m5_n1y_ff  <= 42'(m4_item_ff.first_vel_y) - 42'($signed(m4_t1y_ff[68:28]));
         m5_n2x_ff  <= 42'(m4_item_ff.second_vel_x) + 42'($signed(m4_t2x_ff[68:28]));
         m5_n2y_ff  <= 42'(m4_item_ff.second_vel_y) + 42'($signed(m4_t2y_ff[68:28]));
         m5_p1x_ff  <= m4_p1x_ff;
         m5_p1y_ff  <= m4_p1y_ff;
         m5_p2x_ff  <= m4_p2x_ff;
         m5_p2y_ff  <= m4_p2y_ff;

         m6_ff.new_first_pos_x  <= m5_p1x_ff;
         m6_ff.new_first_pos_y  <= m5_p1y_ff;
         m6_ff.new_second_pos_x <= m5_p2x_ff;
         m6_ff.new_second_pos_y <= m5_p2y_ff;
         m6_ff.contact_status   <= m5_st_ff;
         if (res5) begin
            m6_ff.new_first_vel_x  <= ppcr_pkg::sat32(48'($signed(g1x_c[59:16])));
            m6_ff.new_first_vel_y  <= ppcr_pkg::sat32(48'($signed(g1y_c[59:16])));
            m6_ff.new_second_vel_x <= ppcr_pkg::sat32(48'($signed(g2x_c[59:16])));
            m6_ff.new_second_vel_y <= ppcr_pkg::sat32(48'($signed(g2y_c[59:16])));
         end else begin
            m6_ff.new_first_vel_x  <= m5_item_ff.first_vel_x;
            m6_ff.new_first_vel_y  <= m5_item_ff.first_vel_y;
            m6_ff.new_second_vel_x <= m5_item_ff.second_vel_x;
            m6_ff.new_second_vel_y <= m5_item_ff.second_vel_y;
         end
      end
   end

endmodule

`default_nettype wire

[bench/tb_particle_pair_collision_resolve.sv]
// ----------------------------------------------------------------------------
// tb_particle_pair_collision_resolve
// Drives disc pairs through the collision response block under bursty input
// and a stalling receiver. Each result is checked against an in-bench model
// of the response math. The damping gain is swept across several settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_particle_pair_collision_resolve;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CYCLE_LIMIT = 600000;
   localparam int  DRAIN_WAIT  = 100;
   localparam int  RAND_ITEMS  = 2000;
   localparam logic [2:0] GAIN_ADDR = 3'd0;

   typedef struct {
      ppcr_pkg::req_type pair;
      bit                typed;
      ppcr_pkg::rsp_type want;
   } row_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ppcr_req_if req_if ();
   ppcr_rsp_if rsp_if ();

   particle_pair_collision_resolve dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if.sink),
      .rsp_bus     (rsp_if.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ppcr_pkg::rsp_type pending_rsp[$];
   logic [16:0]       gain_shadow;
   int                errors;
   int                cycles;
   int                stall_phase;
   int                stall_len;
   row_type           rows[$];

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%t timeout", $realtime);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model
   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic ppcr_pkg::rsp_type resolve_pair(ppcr_pkg::req_type p,
                                                      logic [16:0] gain);
      ppcr_pkg::rsp_type o;
      longint          ax, ay, bx, by, dx, dy, adx, ady, rsum, root_len, ux, uy;
      longint          vn, w1, w2, j1, j2, n1x, n1y, n2x, n2y, g, ov, px, py;
      longint unsigned d2, r2, msum;
      ax = longint'(p.first_pos_x);
      ay = longint'(p.first_pos_y);
      bx = longint'(p.second_pos_x);
      by = longint'(p.second_pos_y);
      o.new_first_pos_x  = p.first_pos_x;
      o.new_first_pos_y  = p.first_pos_y;
      o.new_first_vel_x  = p.first_vel_x;
      o.new_first_vel_y  = p.first_vel_y;
      o.new_second_pos_x = p.second_pos_x;
      o.new_second_pos_y = p.second_pos_y;
      o.new_second_vel_x = p.second_vel_x;
      o.new_second_vel_y = p.second_vel_y;
      o.contact_status   = ppcr_pkg::ST_APART;
      dx = ax - bx;
      dy = ay - by;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      rsum = longint'({1'b0, p.first_radius}) + longint'({1'b0, p.second_radius});
      if (adx > rsum || ady > rsum) return o;
      d2 = dx * dx + dy * dy;
      r2 = rsum * rsum;
      if (d2 > r2) return o;
      if (d2 == 0) begin
         o.contact_status = ppcr_pkg::ST_COINCIDENT;
         return o;
      end
      root_len = longint'(root_floor(d2));
      ux = (dx * (64'sd1 <<< ppcr_pkg::UNIT_FRAC)) / root_len;
      uy = (dy * (64'sd1 <<< ppcr_pkg::UNIT_FRAC)) / root_len;
      vn = ((longint'(p.first_vel_x) - longint'(p.second_vel_x)) * ux +
            (longint'(p.first_vel_y) - longint'(p.second_vel_y)) * uy)
           >>> ppcr_pkg::UNIT_FRAC;
      msum = p.first_mass + p.second_mass;
      if (msum == 0) begin
         w1 = 64'sd1 <<< ppcr_pkg::GAIN_FRAC;
         w2 = w1;
      end else begin
         w1 = longint'(((64'd2 * p.second_mass) << ppcr_pkg::GAIN_FRAC) / msum);
         w2 = longint'(((64'd2 * p.first_mass) << ppcr_pkg::GAIN_FRAC) / msum);
      end
      j1 = (vn * w1) >>> ppcr_pkg::GAIN_FRAC;
      j2 = (vn * w2) >>> ppcr_pkg::GAIN_FRAC;
      n1x = longint'(p.first_vel_x) - ((j1 * ux) >>> ppcr_pkg::UNIT_FRAC);
      n1y = longint'(p.first_vel_y) - ((j1 * uy) >>> ppcr_pkg::UNIT_FRAC);
      n2x = longint'(p.second_vel_x) + ((j2 * ux) >>> ppcr_pkg::UNIT_FRAC);
      n2y = longint'(p.second_vel_y) + ((j2 * uy) >>> ppcr_pkg::UNIT_FRAC);
      g = longint'({1'b0, gain});
      o.new_first_vel_x  = clamp32((n1x * g) >>> ppcr_pkg::GAIN_FRAC);
      o.new_first_vel_y  = clamp32((n1y * g) >>> ppcr_pkg::GAIN_FRAC);
      o.new_second_vel_x = clamp32((n2x * g) >>> ppcr_pkg::GAIN_FRAC);
      o.new_second_vel_y = clamp32((n2y * g) >>> ppcr_pkg::GAIN_FRAC);
      ov = rsum - root_len;
      px = (ux * ov) >>> (ppcr_pkg::UNIT_FRAC + 1);
      py = (uy * ov) >>> (ppcr_pkg::UNIT_FRAC + 1);
      o.new_first_pos_x  = clamp32(ax + px);
      o.new_first_pos_y  = clamp32(ay + py);
      o.new_second_pos_x = clamp32(bx - px);
      o.new_second_pos_y = clamp32(by - py);
      o.contact_status   = ppcr_pkg::ST_RESOLVED;
      return o;
   endfunction

   function automatic ppcr_pkg::rsp_type unchanged(ppcr_pkg::req_type p,
                                                   ppcr_pkg::status_type s);
      ppcr_pkg::rsp_type o;
      o.new_first_pos_x  = p.first_pos_x;
      o.new_first_pos_y  = p.first_pos_y;
      o.new_first_vel_x  = p.first_vel_x;
      o.new_first_vel_y  = p.first_vel_y;
      o.new_second_pos_x = p.second_pos_x;
      o.new_second_pos_y = p.second_pos_y;
      o.new_second_vel_x = p.second_vel_x;
      o.new_second_vel_y = p.second_vel_y;
      o.contact_status   = s;
      return o;
   endfunction

   // ------------------------------------------------------------- receiver
   always @(posedge clock) begin
      ppcr_pkg::rsp_type got, want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_phase  <= 0;
         stall_len    <= 8;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (pending_rsp.size() == 0) begin
               $display("%t unexpected result %h", $realtime, got);
               errors = errors + 1;
            end else begin
               want = pending_rsp.pop_front();
               if (got.new_first_pos_x !== want.new_first_pos_x)
                  $display("%t first_pos_x exp %h got %h", $realtime,
                           want.new_first_pos_x, got.new_first_pos_x);
               if (got.new_first_pos_y !== want.new_first_pos_y)
                  $display("%t first_pos_y exp %h got %h", $realtime,
                           want.new_first_pos_y, got.new_first_pos_y);
               if (got.new_first_vel_x !== want.new_first_vel_x)
                  $display("%t first_vel_x exp %h got %h", $realtime,
                           want.new_first_vel_x, got.new_first_vel_x);
               if (got.new_first_vel_y !== want.new_first_vel_y)
                  $display("%t first_vel_y exp %h got %h", $realtime,
                           want.new_first_vel_y, got.new_first_vel_y);
               if (got.new_second_pos_x !== want.new_second_pos_x)
                  $display("%t second_pos_x exp %h got %h", $realtime,
                           want.new_second_pos_x, got.new_second_pos_x);
               if (got.new_second_pos_y !== want.new_second_pos_y)
                  $display("%t second_pos_y exp %h got %h", $realtime,
                           want.new_second_pos_y, got.new_second_pos_y);
               if (got.new_second_vel_x !== want.new_second_vel_x)
                  $display("%t second_vel_x exp %h got %h", $realtime,
                           want.new_second_vel_x, got.new_second_vel_x);
               if (got.new_second_vel_y !== want.new_second_vel_y)
                  $display("%t second_vel_y exp %h got %h", $realtime,
                           want.new_second_vel_y, got.new_second_vel_y);
               if (got.contact_status !== want.contact_status)
                  $display("%t contact_status exp %0d got %0d", $realtime,
                           want.contact_status, got.contact_status);
               if (got !== want) errors = errors + 1;
            end
         end
         // stall pattern: stretches of random length, each randomly open or stalled
         if (stall_phase >= stall_len) begin
            stall_phase <= 0;
            stall_len   <= $urandom_range(1, 40);
            rsp_if.ready <= ($urandom_range(0, 2) != 0);
         end else begin
            stall_phase <= stall_phase + 1;
         end
      end
   end

   // --------------------------------------------------------------- sender
   task automatic send_pair(ppcr_pkg::req_type p);
      req_if.valid <= 1'b1;
      req_if.data  <= p;
      do @(posedge clock); while (!req_if.ready);
      pending_rsp.insert(pending_rsp.size(), resolve_pair(p, gain_shadow));
   endtask

   task automatic csr_write(logic [16:0] value);
      logic [31:0] rd;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= GAIN_ADDR;
      csr_pwdata  <= {15'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      gain_shadow = value;
      if (rd[16:0] !== value) begin
         $display("%t damping_gain readback exp %h got %h", $realtime, value, rd);
         errors = errors + 1;
      end
   endtask

   // hold off until the pipeline is empty
   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic ppcr_pkg::req_type random_pair();
      ppcr_pkg::req_type p;
      int      kind;
      longint  rsum, ddx, ddy;
      kind = $urandom_range(0, 19);
      p.first_pos_x  = $urandom();
      p.first_pos_y  = $urandom();
      p.first_vel_x  = $urandom();
      p.first_vel_y  = $urandom();
      p.second_vel_x = $urandom();
      p.second_vel_y = $urandom();
      p.first_mass   = ($urandom_range(0, 9) == 0) ? 16'd1 : 16'($urandom_range(1, 65535));
      p.second_mass  = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
      case ($urandom_range(0, 4))
         0: p.first_radius = 25'h100_0000;
         1: p.first_radius = 25'd0;
         default: p.first_radius = 25'($urandom_range(0, 16777216));
      endcase
      p.second_radius = ($urandom_range(0, 4) == 0) ? 25'h100_0000
                                                    : 25'($urandom_range(0, 16777216));
      if ($urandom_range(0, 7) == 0) begin
         p.first_vel_x  = 32'sh7FFF_FFFF;
         p.second_vel_x = 32'sh8000_0000;
      end
      rsum = longint'(p.first_radius) + longint'(p.second_radius);
      if (kind < 14) begin
         ddx = longint'($urandom_range(0, 32'(2 * rsum))) - rsum;
         ddy = longint'($urandom_range(0, 32'(2 * rsum))) - rsum;
         p.second_pos_x = 32'(longint'(p.first_pos_x) - ddx);
         p.second_pos_y = 32'(longint'(p.first_pos_y) - ddy);
      end else if (kind < 16) begin
         p.second_pos_x = p.first_pos_x;
         p.second_pos_y = p.first_pos_y;
      end else begin
         p.second_pos_x = $urandom();
         p.second_pos_y = $urandom();
      end
      return p;
   endfunction

   function automatic ppcr_pkg::req_type make_pair(int ax, int ay, int bx, int by,
                                                   int avx, int bvx,
                                                   logic [15:0] am, logic [15:0] bm,
                                                   logic [24:0] ar, logic [24:0] br);
      ppcr_pkg::req_type p;
      p.first_pos_x = ax;   p.first_pos_y = ay;
      p.second_pos_x = bx;  p.second_pos_y = by;
      p.first_vel_x = avx;  p.first_vel_y = -avx;
      p.second_vel_x = bvx; p.second_vel_y = -bvx;
      p.first_mass = am;    p.second_mass = bm;
      p.first_radius = ar;  p.second_radius = br;
      return p;
   endfunction

   task automatic add_row(ppcr_pkg::req_type p, bit typed, ppcr_pkg::status_type s);
      row_type r;
      r.pair  = p;
      r.typed = typed;
      r.want  = unchanged(p, s);
      rows.insert(rows.size(), r);
   endtask

   initial begin
      logic [16:0]       gains[6];
      ppcr_pkg::req_type p;
      ppcr_pkg::rsp_type w;
      int                sent;
      int                burst;
      errors      = 0;
      cycles      = 0;
      gain_shadow = 17'h10000;
      reset       = 1'b1;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, gain at its reset value
      add_row(make_pair(0, 0, 32'sh0300_0000, 0, 5, 7, 16'h0100, 16'h0100,
                        25'h100_0000, 25'h100_0000), 1, ppcr_pkg::ST_APART);
      add_row(make_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                        32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 16'h0001,
                        25'h100_0000, 25'h100_0000), 1, ppcr_pkg::ST_APART);
      add_row(make_pair(32'sh1234_5678, -32'sh10, 32'sh1234_5678, -32'sh10, 32'sh7FFF_FFFF,
                        32'sh8000_0000, 16'hFFFF, 16'hFFFF, 25'd0, 25'd0), 1,
              ppcr_pkg::ST_COINCIDENT);
      add_row(make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                        1, -1, 16'h0001, 16'h0001, 25'h100_0000, 25'h100_0000),
              1, ppcr_pkg::ST_COINCIDENT);
      add_row(make_pair(0, 0, 1, 0, 1, 0, 16'h0001, 16'h0001, 25'd0, 25'd0), 1,
              ppcr_pkg::ST_APART);
      // contact cases, checked against the model
      add_row(make_pair(0, 0, 32'sh0100_0000, 0, 32'sh0100_0000, -32'sh0100_0000,
                        16'h0100, 16'h0100, 25'h100_0000, 25'h100_0000), 0,
              ppcr_pkg::ST_APART);
      add_row(make_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_0000, 32'sh7FFF_0000,
                        32'sh7FFF_FFFF, 32'sh8000_0000, 16'h0001, 16'hFFFF,
                        25'h100_0000, 25'h100_0000), 0, ppcr_pkg::ST_APART);
      add_row(make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0100, 32'sh8000_0100,
                        32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF, 16'h0001,
                        25'h100_0000, 25'h100_0000), 0, ppcr_pkg::ST_APART);
      add_row(make_pair(0, 0, 32'sh0200_0000, 0, 32'sh0100_0000, 0, 16'h0100, 16'h0100,
                        25'h100_0000, 25'h100_0000), 0, ppcr_pkg::ST_APART);
      add_row(make_pair(1, 1, 0, 0, 32'sh7FFF_FFFF, 0, 16'hFFFF, 16'hFFFF, 25'd1, 25'd1),
              0, ppcr_pkg::ST_APART);
      add_row(make_pair(-32'sh0080_0000, 32'sh0040_0000, 32'sh0010_0000, -32'sh0020_0000,
                        32'sh0123_4567, -32'sh0765_4321, 16'h0080, 16'h3000,
                        25'h080_0000, 25'h0C0_0000), 0, ppcr_pkg::ST_APART);
      foreach (rows[i]) begin
         p = rows[i].pair;
         if (rows[i].typed) begin
            w = rows[i].want;
            req_if.valid <= 1'b1;
            req_if.data  <= p;
            do @(posedge clock); while (!req_if.ready);
            pending_rsp.insert(pending_rsp.size(), w);
         end else begin
            send_pair(p);
         end
      end
      drain();

      gains[0] = 17'h10000;
      gains[1] = 17'h00000;
      gains[2] = 17'h00001;
      gains[3] = 17'h08000;
      gains[4] = 17'($urandom_range(0, 65536));
      gains[5] = 17'h1FFFF;
      foreach (gains[k]) begin
         csr_write(gains[k]);
         sent = 0;
         while (sent < RAND_ITEMS / 6) begin
            burst = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
            repeat (burst) begin
               if (sent < RAND_ITEMS / 6) begin
                  send_pair(random_pair());
                  sent = sent + 1;
               end
            end
            if ($urandom_range(0, 3) != 0) begin
               req_if.valid <= 1'b0;
               repeat ($urandom_range(1, 20)) @(posedge clock);
            end
         end
         drain();
      end

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

[particle_pair_collision_resolve.f]
rtl/ppcr_pkg.sv
rtl/ppcr_chan_if.sv
rtl/ppcr_front.sv
rtl/ppcr_queue.sv
rtl/ppcr_back.sv
rtl/particle_pair_collision_resolve.sv
bench/tb_particle_pair_collision_resolve.sv
